// ----- src/eht_pkg.sv -----
// Shared types, constants and helpers for the entropy health test block.
`timescale 1ns / 1ps

package eht_pkg;

  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned TOTAL_W     = 32;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_RCT_CUTOFF = 2'd0,
    CFG_APT_CUTOFF = 2'd1,
    CFG_APT_WINDOW = 2'd2
  } cfg_reg_t;

  // Per-word outcome of the repetition count test
  typedef struct packed {
    logic               pass;
    logic [TOTAL_W-1:0] failure_total;
  } rct_res_t;

  // Per-word outcome of the adaptive proportion test
  typedef struct packed {
    logic               pass;
    logic [TOTAL_W-1:0] failure_total;
    logic [TOTAL_W-1:0] window_total;
  } apt_res_t;

  function automatic logic [COUNT_W-1:0] sat_inc16(input logic [COUNT_W-1:0] v);
    sat_inc16 = (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [TOTAL_W-1:0] sat_inc32(input logic [TOTAL_W-1:0] v);
    sat_inc32 = (&v) ? v : v + 1'b1;
  endfunction

endpackage

// ----- src/eht_rct.sv -----
// Repetition count test: run tracking, pass flag and saturating failure total.
`timescale 1ns / 1ps

module eht_rct #(
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic [SAMPLE_BITS-1:0]         sample,
  input  logic [eht_pkg::COUNT_W-1:0]    cutoff,
  output eht_pkg::rct_res_t              res
);

  logic                          seen_any;
  logic [SAMPLE_BITS-1:0]        last_value;
  logic [eht_pkg::COUNT_W-1:0]   run_length;
  logic [eht_pkg::TOTAL_W-1:0]   failures;

  logic                          is_repeat;
  logic [eht_pkg::COUNT_W-1:0]   run_inc;
  logic [eht_pkg::COUNT_W-1:0]   run_length_next;
  logic [eht_pkg::TOTAL_W-1:0]   failures_next;
  logic                          pass;

  // Extend the run on a repeat, otherwise restart it at this word
  always_comb begin
    is_repeat       = seen_any && (sample == last_value);
    run_inc         = eht_pkg::sat_inc16(run_length);
    run_length_next = is_repeat ? run_inc : eht_pkg::COUNT_W'(1);
    pass            = !(is_repeat && (run_inc >= cutoff));
    failures_next   = pass ? failures : eht_pkg::sat_inc32(failures);
  end

  assign res.pass          = pass;
  assign res.failure_total = failures_next;

  // Advance test state once per word
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_any   <= 1'b0;
      last_value <= '0;
      run_length <= '0;
      failures   <= '0;
    end else if (step) begin
      seen_any   <= 1'b1;
      last_value <= sample;
      run_length <= run_length_next;
      failures   <= failures_next;
    end
  end

endmodule

// ----- src/eht_apt.sv -----
// Adaptive proportion test: window tracking, pass flag and window totals.
`timescale 1ns / 1ps

module eht_apt #(
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic [SAMPLE_BITS-1:0]         sample,
  input  logic [eht_pkg::COUNT_W-1:0]    cutoff,
  input  logic [eht_pkg::COUNT_W-1:0]    window,
  input  logic                           window_load,
  input  logic [eht_pkg::COUNT_W-1:0]    load_value,
  output eht_pkg::apt_res_t              res
);

  logic [SAMPLE_BITS-1:0]        reference;
  logic [eht_pkg::COUNT_W-1:0]   match_count;
  logic [eht_pkg::COUNT_W-1:0]   window_index;
  logic [eht_pkg::TOTAL_W-1:0]   window_total;
  logic [eht_pkg::TOTAL_W-1:0]   window_failures;

  logic                          new_window;
  logic                          pass;
  logic                          window_done;
  logic [eht_pkg::COUNT_W-1:0]   match_count_next;
  logic [eht_pkg::COUNT_W-1:0]   window_index_next;
  logic [eht_pkg::TOTAL_W-1:0]   window_total_next;
  logic [eht_pkg::TOTAL_W-1:0]   window_failures_next;
  logic [SAMPLE_BITS-1:0]        reference_next;

  // Start a window, or count a match and close the window at its end
  always_comb begin
    new_window           = window_index >= window;
    reference_next       = reference;
    match_count_next     = match_count;
    window_index_next    = window_index;
    window_total_next    = window_total;
    window_failures_next = window_failures;
    pass                 = 1'b1;
    window_done          = 1'b0;
    if (new_window) begin
      reference_next    = sample;
      match_count_next  = eht_pkg::COUNT_W'(1);
      window_index_next = eht_pkg::COUNT_W'(1);
    end else begin
      if (sample == reference) begin
        match_count_next = eht_pkg::sat_inc16(match_count);
      end
      pass              = !(match_count_next >= cutoff);
      window_index_next = eht_pkg::sat_inc16(window_index);
      window_done       = window_index_next >= window;
      if (window_done) begin
        window_total_next = eht_pkg::sat_inc32(window_total);
        if (!pass) begin
          window_failures_next = eht_pkg::sat_inc32(window_failures);
        end
      end
    end
  end

  assign res.pass          = pass;
  assign res.failure_total = window_failures_next;
  assign res.window_total  = window_total_next;

  // Hold window state; a window size write forces a fresh window
  always_ff @(posedge clk) begin
    if (rst) begin
      reference       <= '0;
      match_count     <= '0;
      window_index    <= '0;
      window_total    <= '0;
      window_failures <= '0;
    end else if (window_load) begin
      window_index    <= load_value;
    end else if (step) begin
      reference       <= reference_next;
      match_count     <= match_count_next;
      window_index    <= window_index_next;
      window_total    <= window_total_next;
      window_failures <= window_failures_next;
    end
  end

endmodule

// ----- src/entropy_health_tests_top.sv -----
// Top level of the entropy health tests: handshake, config and result register.
`timescale 1ns / 1ps

// Runs the repetition count test and the adaptive proportion test on a stream
// of raw noise samples, one sample word in and one result word out per sample.
// A new word can be taken every clock while out_ready drains the result register:
// each word is captured in an input register, tested by the compare and counter
// logic, and placed in the result register once that register is free, so the
// sustained rate is one word per cycle, limited only by out_ready.
// Only the low SAMPLE_WIDTH bits of a sample take part in the compares.
// The totals in each result are the running counts after that sample.
// Write the cutoff and window registers only while no word is in flight;
// writing the window length also restarts the adaptive proportion window.
module entropy_health_tests_top #(
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [31:0]                         sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                credit,
  output logic                                rep_ok,
  output logic                                prop_ok,
  output logic [eht_pkg::TOTAL_W-1:0]         rct_failure_total,
  output logic [eht_pkg::TOTAL_W-1:0]         apt_failure_total,
  output logic [eht_pkg::TOTAL_W-1:0]         apt_window_total,
  input  logic                                cfg_we,
  input  logic [eht_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [eht_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int unsigned STORE_W = (SAMPLE_WIDTH < 32) ? SAMPLE_WIDTH : 32;

  logic [eht_pkg::COUNT_W-1:0] rep_limit;
  logic [eht_pkg::COUNT_W-1:0] prop_limit;
  logic [eht_pkg::COUNT_W-1:0] prop_window_len;
  logic                        window_load;

  logic                        s1_valid;
  logic [STORE_W-1:0]          s1_sample;
  logic                        advance;

  eht_pkg::rct_res_t           rct_res;
  eht_pkg::apt_res_t           apt_res;

  // Decode configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      rep_limit       <= '0;
      prop_limit      <= '0;
      prop_window_len <= '0;
    end else if (cfg_we) begin
      case (eht_pkg::cfg_reg_t'(cfg_index))
        eht_pkg::CFG_RCT_CUTOFF: rep_limit       <= cfg_data;
        eht_pkg::CFG_APT_CUTOFF: prop_limit      <= cfg_data;
        eht_pkg::CFG_APT_WINDOW: prop_window_len <= cfg_data;
        default: ;
      endcase
    end
  end

  assign window_load = cfg_we && (eht_pkg::cfg_reg_t'(cfg_index) == eht_pkg::CFG_APT_WINDOW);

  // Move a word from the input register whenever the result register frees up
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Capture the incoming word
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample <= sample[STORE_W-1:0];
    end
  end

  eht_rct #(
    .SAMPLE_BITS (STORE_W)
  ) u_rct (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .sample (s1_sample),
    .cutoff (rep_limit),
    .res    (rct_res)
  );

  eht_apt #(
    .SAMPLE_BITS (STORE_W)
  ) u_apt (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .sample      (s1_sample),
    .cutoff      (prop_limit),
    .window      (prop_window_len),
    .window_load (window_load),
    .load_value  (cfg_data),
    .res         (apt_res)
  );

  // Load the result register, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid         <= 1'b0;
      credit            <= 1'b0;
      rep_ok            <= 1'b0;
      prop_ok           <= 1'b0;
      rct_failure_total <= '0;
      apt_failure_total <= '0;
      apt_window_total  <= '0;
    end else if (advance) begin
      out_valid         <= 1'b1;
      credit            <= rct_res.pass & apt_res.pass;
      rep_ok            <= rct_res.pass;
      prop_ok           <= apt_res.pass;
      rct_failure_total <= rct_res.failure_total;
      apt_failure_total <= apt_res.failure_total;
      apt_window_total  <= apt_res.window_total;
    end else if (out_ready) begin
      out_valid         <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  // An empty result register must never block intake
  assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // The repetition failure total only grows
  assert property (@(posedge clk) disable iff (rst)
    ##1 (rct_failure_total >= $past(rct_failure_total)))
    else $error("repetition failure total decreased");

  // A failed window is always a counted window
  assert property (@(posedge clk) disable iff (rst)
    apt_failure_total <= apt_window_total)
    else $error("window failures exceed completed windows");

  // A repetition failure shows in the running total
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rep_ok) |-> (rct_failure_total != '0))
    else $error("repetition failure not counted");
`endif

endmodule

// ----- bench/eht_result_checker.sv -----
// Checker for the entropy health tests: predicts each result word and compares it.
`timescale 1ns / 1ps

module eht_result_checker #(
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [31:0]                     sample,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            credit,
  input  logic                            rep_ok,
  input  logic                            prop_ok,
  input  logic [eht_pkg::TOTAL_W-1:0]     rct_failure_total,
  input  logic [eht_pkg::TOTAL_W-1:0]     apt_failure_total,
  input  logic [eht_pkg::TOTAL_W-1:0]     apt_window_total,
  input  logic                            cfg_we,
  input  logic [eht_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [eht_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              mismatches,
  output int                              outstanding,
  output int                              words_checked,
  output int                              rct_rejects,
  output int                              apt_rejects
);

  localparam logic [31:0] SAMPLE_MASK = 32'((64'h1 << SAMPLE_WIDTH) - 1);
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic                        credit;
    logic                        rep_ok;
    logic                        prop_ok;
    logic [eht_pkg::TOTAL_W-1:0] rep_fails;
    logic [eht_pkg::TOTAL_W-1:0] window_failures;
    logic [eht_pkg::TOTAL_W-1:0] windows_done;
  } health_word_t;

  // Register copies
  logic [eht_pkg::CFG_DATA_W-1:0] rct_limit;
  logic [eht_pkg::CFG_DATA_W-1:0] apt_limit;
  logic [eht_pkg::CFG_DATA_W-1:0] window_len;

  // Repetition count state
  logic                        any_seen;
  logic [31:0]                 run_value;
  logic [eht_pkg::COUNT_W-1:0] run_count;
  logic [eht_pkg::TOTAL_W-1:0] rct_fail_count;

  // Adaptive proportion state
  logic [31:0]                 ref_value;
  logic [eht_pkg::COUNT_W-1:0] ref_matches;
  logic [eht_pkg::COUNT_W-1:0] window_pos;
  logic [eht_pkg::TOTAL_W-1:0] windows_done;
  logic [eht_pkg::TOTAL_W-1:0] windows_failed;

  health_word_t expected_grades[$];

  function automatic logic [eht_pkg::COUNT_W-1:0] bump16(
      input logic [eht_pkg::COUNT_W-1:0] v);
    return (v == {eht_pkg::COUNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic logic [eht_pkg::TOTAL_W-1:0] bump32(
      input logic [eht_pkg::TOTAL_W-1:0] v);
    return (v == {eht_pkg::TOTAL_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  // Advance both tests by one sample and return the word the block should emit
  function automatic health_word_t grade_sample(input logic [31:0] raw);
    logic [31:0]  s;
    logic         rct_ok;
    logic         apt_ok;
    health_word_t g;
    s      = raw & SAMPLE_MASK;
    rct_ok = 1'b1;
    apt_ok = 1'b1;
    // repetition count: extend the run on a repeat, else restart it
    if (any_seen && s == run_value) begin
      run_count = bump16(run_count);
      if (run_count >= rct_limit) rct_ok = 1'b0;
    end else begin
      run_value = s;
      run_count = eht_pkg::COUNT_W'(1);
    end
    any_seen = 1'b1;
    if (!rct_ok) rct_fail_count = bump32(rct_fail_count);
    // adaptive proportion: open a window or count matches inside it
    if (window_pos >= window_len) begin
      ref_value   = s;
      ref_matches = eht_pkg::COUNT_W'(1);
      window_pos  = eht_pkg::COUNT_W'(1);
    end else begin
      if (s == ref_value) ref_matches = bump16(ref_matches);
      if (ref_matches >= apt_limit) apt_ok = 1'b0;
      window_pos = bump16(window_pos);
      if (window_pos >= window_len) begin
        windows_done = bump32(windows_done);
        if (!apt_ok) windows_failed = bump32(windows_failed);
      end
    end
    g.credit          = rct_ok & apt_ok;
    g.rep_ok          = rct_ok;
    g.prop_ok         = apt_ok;
    g.rep_fails       = rct_fail_count;
    g.window_failures = windows_failed;
    g.windows_done    = windows_done;
    return g;
  endfunction

  function automatic void report_mismatch(input string what, input health_word_t want,
                                          input health_word_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("[%0t] mismatch %0d (%s):", $realtime, mismatches, what);
      $display("  expected c/r/a=%b%b%b totals %0d/%0d/%0d",
               want.credit, want.rep_ok, want.prop_ok,
               want.rep_fails, want.window_failures, want.windows_done);
      $display("  actual   c/r/a=%b%b%b totals %0d/%0d/%0d",
               got.credit, got.rep_ok, got.prop_ok,
               got.rep_fails, got.window_failures, got.windows_done);
    end
  endfunction

  initial begin
    mismatches    = 0;
    outstanding   = 0;
    words_checked = 0;
    rct_rejects   = 0;
    apt_rejects   = 0;
  end

  always @(posedge clk) begin : watch
    health_word_t want;
    health_word_t got;
    if (rst) begin
      // hold everything at its reset value
      rct_limit      = '0;
      apt_limit      = '0;
      window_len     = '0;
      any_seen       = 1'b0;
      run_value      = '0;
      run_count      = '0;
      rct_fail_count = '0;
      ref_value      = '0;
      ref_matches    = '0;
      window_pos     = '0;
      windows_done   = '0;
      windows_failed = '0;
      expected_grades.delete();
    end else begin
      // track register writes; unknown indexes are dropped
      if (cfg_we) begin
        case (cfg_index)
          eht_pkg::CFG_RCT_CUTOFF: rct_limit = cfg_data;
          eht_pkg::CFG_APT_CUTOFF: apt_limit = cfg_data;
          eht_pkg::CFG_APT_WINDOW: begin
            window_len = cfg_data;
            window_pos = cfg_data;
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_grades.push_back(grade_sample(sample));
      // compare each result word with the oldest prediction
      if (out_valid && out_ready) begin
        got.credit          = credit;
        got.rep_ok          = rep_ok;
        got.prop_ok         = prop_ok;
        got.rep_fails       = rct_failure_total;
        got.window_failures = apt_failure_total;
        got.windows_done    = apt_window_total;
        if (expected_grades.size() == 0) begin
          report_mismatch("word with nothing expected", '0, got);
        end else begin
          want = expected_grades.pop_front();
          words_checked++;
          if (!want.rep_ok) rct_rejects++;
          if (!want.prop_ok) apt_rejects++;
          if (want != got) report_mismatch("wrong field", want, got);
        end
      end
    end
    outstanding = expected_grades.size();
  end

endmodule

// ----- bench/entropy_health_tests_top_test.sv -----
// Testbench top: drives samples and register writes into the health tests, gives the verdict.
`timescale 1ns / 1ps

module entropy_health_tests_top_test;

  localparam logic [eht_pkg::CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 2'd3;
  localparam int unsigned BLOCKS_PER_PHASE = 5;
  localparam int unsigned WORDS_PER_BLOCK  = 75;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [31:0]                     sample = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            credit;
  logic                            rep_ok;
  logic                            prop_ok;
  logic [eht_pkg::TOTAL_W-1:0]     rct_failure_total;
  logic [eht_pkg::TOTAL_W-1:0]     apt_failure_total;
  logic [eht_pkg::TOTAL_W-1:0]     apt_window_total;
  logic                            cfg_we = 1'b0;
  logic [eht_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [eht_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  int mismatches;
  int outstanding;
  int words_checked;
  int rct_rejects;
  int apt_rejects;

  int          send_idle_pct = 18;
  int          recv_stall_pct = 88;
  int          settings_used = 0;
  int          words_sent = 0;
  logic [31:0] last_sample = '0;
  logic [31:0] alphabet[4];

  always #6 clk = ~clk;

  entropy_health_tests_top u_top (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .sample            (sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .credit            (credit),
    .rep_ok            (rep_ok),
    .prop_ok           (prop_ok),
    .rct_failure_total (rct_failure_total),
    .apt_failure_total (apt_failure_total),
    .apt_window_total  (apt_window_total),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  eht_result_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .sample            (sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .credit            (credit),
    .rep_ok            (rep_ok),
    .prop_ok           (prop_ok),
    .rct_failure_total (rct_failure_total),
    .apt_failure_total (apt_failure_total),
    .apt_window_total  (apt_window_total),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatches        (mismatches),
    .outstanding       (outstanding),
    .words_checked     (words_checked),
    .rct_rejects       (rct_rejects),
    .apt_rejects       (apt_rejects)
  );

  // Stall the result side at random
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offer one sample word, with a random gap first, and hold it until taken
  task automatic push_sample(input logic [31:0] value);
    logic taken;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    sample   <= value;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    last_sample = value;
    words_sent++;
  endtask

  // Drop valid, wait for every result word, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [eht_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [eht_pkg::CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [eht_pkg::CFG_DATA_W-1:0] rct_cut,
                            input logic [eht_pkg::CFG_DATA_W-1:0] apt_cut,
                            input logic [eht_pkg::CFG_DATA_W-1:0] window);
    settle();
    write_reg(eht_pkg::CFG_RCT_CUTOFF, rct_cut);
    write_reg(eht_pkg::CFG_APT_CUTOFF, apt_cut);
    write_reg(eht_pkg::CFG_APT_WINDOW, window);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Mostly repeats or values from a small set, so runs and matches build up
  function automatic logic [31:0] pick_sample();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return last_sample;
    if (r < 88) return alphabet[$urandom_range(3)];
    return $urandom();
  endfunction

  task automatic random_block(input int count);
    int unsigned window;
    int unsigned rct_cut;
    int unsigned apt_cut;
    window  = ($urandom_range(99) < 15) ? $urandom_range(1) : $urandom_range(2, 24);
    rct_cut = ($urandom_range(99) < 20) ? $urandom_range(1) : $urandom_range(2, 8);
    if ($urandom_range(99) < 5) rct_cut = $urandom_range(9, 65535);
    apt_cut = $urandom_range(0, window + 2);
    set_config(eht_pkg::CFG_DATA_W'(rct_cut), eht_pkg::CFG_DATA_W'(apt_cut),
               eht_pkg::CFG_DATA_W'(window));
    // a pair that differs in a single bit and a pair that differs in every bit exercise the compare
    alphabet[0] = $urandom();
    alphabet[1] = alphabet[0] ^ (32'h1 << $urandom_range(31));
    alphabet[2] = $urandom();
    alphabet[3] = ~alphabet[2];
    repeat (count) push_sample(pick_sample());
  endtask

  task automatic random_phase();
    repeat (BLOCKS_PER_PHASE) random_block(WORDS_PER_BLOCK);
  endtask

  // Stop a hung run
  initial begin
    #(2_000_000);
    $display("entropy_health_tests_top regression: fail");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: zero cutoffs fail every repeat, zero window never closes
    push_sample(32'h0000_0000);
    push_sample(32'h0000_0000);
    push_sample(32'hFFFF_FFFF);
    push_sample(32'hFFFF_FFFF);

    // write to an index past the register list, which must change nothing
    settle();
    write_reg(CFG_SPARE_INDEX, 16'hFFFF);
    cfg_we <= 1'b0;
    push_sample(32'hFFFF_FFFF);

    // cutoffs of one, one-sample windows
    set_config(16'd1, 16'd1, 16'd1);
    push_sample(32'h1234_5678);
    push_sample(32'h1234_5678);
    push_sample(32'h8765_4321);

    // windows closing with and without a failure, run reaching the cutoff
    set_config(16'd3, 16'd2, 16'd4);
    push_sample(32'h0000_00A5);
    push_sample(32'h0000_00A5);
    push_sample(32'h0000_005A);
    push_sample(32'h0000_00A5);
    push_sample(32'h0000_005A);
    push_sample(32'h0000_00A5);
    push_sample(32'h0000_00A5);
    push_sample(32'h0000_00A5);

    // zero APT cutoff: every later sample of a window fails
    set_config(16'd2, 16'd0, 16'd3);
    push_sample(32'hC0DE_0001);
    push_sample(32'hC0DE_0002);
    push_sample(32'hC0DE_0003);

    // widest settings
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_sample(32'h5555_5555);
    push_sample(32'hAAAA_AAAA);

    // sender lightly idle, receiver mostly stalled
    random_phase();

    settle();
    send_idle_pct  = 88;
    recv_stall_pct = 18;
    random_phase();

    settle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_phase();

    settle();
    repeat (8) @(posedge clk);
    $display("Covered %0d sample words (%0d result words checked) under %0d register settings.",
             words_sent, words_checked, settings_used);
    $display("Expected rejections: %0d by the repetition test, %0d by the proportion test.",
             rct_rejects, apt_rejects);
    if (mismatches == 0 && outstanding == 0) begin
      $display("entropy_health_tests_top regression: pass");
    end else begin
      $display("entropy_health_tests_top regression: fail");
    end
    $finish;
  end

endmodule
